@@ design/deq_pkg.sv @@
// Shared types, codes and defaults for the double-ended queue.
package deq_pkg;

    // Fixed widths of the command and result fields.
    localparam int CMD_W    = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    // Defaults for the top-level parameters.
    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_POP   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUMP  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // Decoded command as it travels from the front end to the back end.
    typedef struct packed {
        logic is_clear;
        logic is_push;
        logic is_dump;
        logic is_pop;
        logic at_front;
    } t_op;

endpackage

@@ design/deq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module deq_ram
    import deq_pkg::*;
#(
    parameter int WIDTH = DATA_WIDTH_DEF,
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/deq_front.sv @@
// Front end: takes command beats, decodes them and holds them in a short queue.
module deq_front
    import deq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [CMD_W-1:0]       i_cmd,
    input  logic signed [WORD_W-1:0] i_push_value,
    output logic                   o_op_valid,
    input  logic                   i_op_ready,
    output t_op                    o_op,
    output logic [DATA_WIDTH-1:0]  o_op_value
);

    localparam logic [1:0] Q_FULL = 2'd2;

    t_op                   w_op;
    logic                  w_known;
    logic [DATA_WIDTH-1:0] w_store;
    logic                  w_enq;
    logic                  w_deq;

    t_op                   r_q_op  [2];
    logic [DATA_WIDTH-1:0] r_q_val [2];
    logic                  r_q_wr;
    logic                  r_q_rd;
    logic [1:0]            r_q_cnt;
    logic                  n_q_wr;
    logic                  n_q_rd;
    logic [1:0]            n_q_cnt;

    // Pushed words are sign-extended or truncated to the storage width.
    generate
        if (DATA_WIDTH <= WORD_W) begin : g_narrow
            assign w_store = i_push_value[DATA_WIDTH-1:0];
        end else begin : g_wide
            assign w_store = {{(DATA_WIDTH-WORD_W){i_push_value[WORD_W-1]}}, i_push_value};
        end
    endgenerate

    always_comb begin
        w_op.is_clear = (i_cmd == CMD_CLEAR);
        w_op.is_push  = i_cmd inside {CMD_PUSH_FRONT, CMD_PUSH_BACK};
        w_op.is_dump  = (i_cmd == CMD_DUMP);
        w_op.is_pop   = i_cmd inside {CMD_POP_FRONT, CMD_POP_BACK};
        w_op.at_front = i_cmd inside {CMD_PUSH_FRONT, CMD_POP_FRONT};
        w_known       = w_op.is_clear | w_op.is_push | w_op.is_dump | w_op.is_pop;
    end

    // Unknown command codes are taken and dropped here.
    assign o_ready    = (r_q_cnt != Q_FULL);
    assign w_enq      = i_valid & o_ready & w_known;
    assign o_op_valid = (r_q_cnt != 2'd0);
    assign w_deq      = o_op_valid & i_op_ready;
    assign o_op       = r_q_op[r_q_rd];
    assign o_op_value = r_q_val[r_q_rd];

    always_comb begin
        n_q_wr  = r_q_wr ^ w_enq;
        n_q_rd  = r_q_rd ^ w_deq;
        n_q_cnt = r_q_cnt + {1'b0, w_enq} - {1'b0, w_deq};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wr  <= 1'b0;
            r_q_rd  <= 1'b0;
            r_q_cnt <= 2'd0;
        end else begin
            r_q_wr  <= n_q_wr;
            r_q_rd  <= n_q_rd;
            r_q_cnt <= n_q_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_q_op[r_q_wr]  <= w_op;
            r_q_val[r_q_wr] <= w_store;
        end
    end

endmodule

@@ design/deq_back.sv @@
// Back end: owns the ring pointers and the store, executes commands and buffers results.
module deq_back
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_op_valid,
    output logic                     o_op_ready,
    input  t_op                      i_op,
    input  logic [DATA_WIDTH-1:0]    i_op_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [WORD_W-1:0] o_word,
    output logic [STATUS_W-1:0]      o_status,
    output logic                     o_last
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    localparam logic [1:0] OB_FULL = 2'd2;

    function automatic logic [IDX_W-1:0] f_wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] t;
        t = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
        return t[IDX_W-1:0];
    endfunction

    logic                r_state;
    logic [IDX_W-1:0]    r_front;
    logic [CNT_W-1:0]    r_count;
    logic [IDX_W-1:0]    r_dump_pos;
    logic [CNT_W-1:0]    r_dump_left;
    logic                r_pend;
    logic                r_pend_zero;
    logic [STATUS_W-1:0] r_pend_status;
    logic                r_pend_last;

    logic                n_state;
    logic [IDX_W-1:0]    n_front;
    logic [CNT_W-1:0]    n_count;
    logic [IDX_W-1:0]    n_dump_pos;
    logic [CNT_W-1:0]    n_dump_left;
    logic                n_pend;
    logic                n_pend_zero;
    logic [STATUS_W-1:0] n_pend_status;
    logic                n_pend_last;

    logic [WORD_W-1:0]   r_ob_word   [2];
    logic [STATUS_W-1:0] r_ob_status [2];
    logic                r_ob_last   [2];
    logic                r_ob_wr;
    logic                r_ob_rd;
    logic [1:0]          r_ob_cnt;

    logic                  w_accept;
    logic                  w_we;
    logic [IDX_W-1:0]      w_waddr;
    logic                  w_re;
    logic [IDX_W-1:0]      w_raddr;
    logic [DATA_WIDTH-1:0] w_rdata;
    logic [WORD_W-1:0]     w_rword;
    logic                  w_pop_out;
    logic [2:0]            w_space_used;
    logic                  w_credit;
    logic                  w_full;
    logic                  w_empty;
    logic [IDX_W-1:0]      w_front_inc;
    logic [IDX_W-1:0]      w_front_dec;
    logic [IDX_W-1:0]      w_tail_next;
    logic [IDX_W-1:0]      w_tail;
    logic [IDX_W-1:0]      w_dump_inc;

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_op_value),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    generate
        if (DATA_WIDTH >= WORD_W) begin : g_out_trunc
            assign w_rword = w_rdata[WORD_W-1:0];
        end else begin : g_out_sext
            assign w_rword = {{(WORD_W-DATA_WIDTH){w_rdata[DATA_WIDTH-1]}}, w_rdata};
        end
    endgenerate

    // Result slots: a result may be started only if the output buffer can still
    // hold it once its read has landed.
    assign o_valid      = (r_ob_cnt != 2'd0);
    assign w_pop_out    = o_valid & i_ready;
    assign w_space_used = {1'b0, r_ob_cnt} + {2'b00, r_pend} - {2'b00, w_pop_out};
    assign w_credit     = (w_space_used < 3'd2);

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    assign w_front_inc = f_wrap(SUM_W'(r_front) + SUM_W'(1));
    assign w_front_dec = (r_front == '0) ? IDX_W'(DEPTH - 1) : (r_front - IDX_W'(1));
    assign w_tail_next = f_wrap(SUM_W'(r_front) + SUM_W'(r_count));
    assign w_tail      = f_wrap(SUM_W'(r_front) + SUM_W'(r_count) - SUM_W'(1));
    assign w_dump_inc  = f_wrap(SUM_W'(r_dump_pos) + SUM_W'(1));

    always_comb begin
        n_state       = r_state;
        n_front       = r_front;
        n_count       = r_count;
        n_dump_pos    = r_dump_pos;
        n_dump_left   = r_dump_left;
        n_pend        = 1'b0;
        n_pend_zero   = 1'b0;
        n_pend_status = ST_POP;
        n_pend_last   = 1'b1;
        w_accept      = 1'b0;
        w_we          = 1'b0;
        w_waddr       = r_front;
        w_re          = 1'b0;
        w_raddr       = r_front;
        case (r_state)
            S_IDLE: begin
                if (i_op_valid) begin
                    if (i_op.is_clear) begin
                        w_accept = 1'b1;
                        n_front  = '0;
                        n_count  = '0;
                    end else if (i_op.is_push) begin
                        if (w_full) begin
                            if (w_credit) begin
                                w_accept      = 1'b1;
                                n_pend        = 1'b1;
                                n_pend_zero   = 1'b1;
                                n_pend_status = ST_FULL;
                            end
                        end else begin
                            w_accept = 1'b1;
                            w_we     = 1'b1;
                            n_count  = r_count + CNT_W'(1);
                            if (i_op.at_front) begin
                                w_waddr = w_front_dec;
                                n_front = w_front_dec;
                            end else begin
                                w_waddr = w_tail_next;
                            end
                        end
                    end else if (i_op.is_pop) begin
                        if (w_credit) begin
                            w_accept = 1'b1;
                            n_pend   = 1'b1;
                            if (w_empty) begin
                                n_pend_zero   = 1'b1;
                                n_pend_status = ST_EMPTY;
                            end else begin
                                w_re    = 1'b1;
                                n_count = r_count - CNT_W'(1);
                                if (i_op.at_front) begin
                                    w_raddr = r_front;
                                    n_front = w_front_inc;
                                end else begin
                                    w_raddr = w_tail;
                                end
                            end
                        end
                    end else if (i_op.is_dump) begin
                        w_accept = 1'b1;
                        if (!w_empty) begin
                            n_state     = S_DUMP;
                            n_dump_pos  = r_front;
                            n_dump_left = r_count;
                        end
                    end else begin
                        w_accept = 1'b1;
                    end
                end
            end
            S_DUMP: begin
                if (w_credit) begin
                    w_re          = 1'b1;
                    w_raddr       = r_dump_pos;
                    n_pend        = 1'b1;
                    n_pend_status = ST_DUMP;
                    n_pend_last   = (r_dump_left == CNT_W'(1));
                    n_dump_pos    = w_dump_inc;
                    n_dump_left   = r_dump_left - CNT_W'(1);
                    if (r_dump_left == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_op_ready = w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_front  <= '0;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_ob_wr  <= 1'b0;
            r_ob_rd  <= 1'b0;
            r_ob_cnt <= 2'd0;
        end else begin
            r_state  <= n_state;
            r_front  <= n_front;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_ob_wr  <= r_ob_wr ^ r_pend;
            r_ob_rd  <= r_ob_rd ^ w_pop_out;
            r_ob_cnt <= w_space_used[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_dump_pos    <= n_dump_pos;
        r_dump_left   <= n_dump_left;
        r_pend_zero   <= n_pend_zero;
        r_pend_status <= n_pend_status;
        r_pend_last   <= n_pend_last;
        if (r_pend) begin
            r_ob_word[r_ob_wr]   <= r_pend_zero ? '0 : w_rword;
            r_ob_status[r_ob_wr] <= r_pend_status;
            r_ob_last[r_ob_wr]   <= r_pend_last;
        end
    end

    assign o_word   = r_ob_word[r_ob_rd];
    assign o_status = r_ob_status[r_ob_rd];
    assign o_last   = r_ob_last[r_ob_rd];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front <= IDX_W'(DEPTH - 1))
        else $error("front index outside the ring");

    a_landing_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_ob_cnt != OB_FULL))
        else $error("result landed in a full output buffer");

    a_dump_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> (r_dump_left != '0) && (r_dump_left <= r_count))
        else $error("dump run has no entries left");

    a_dump_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> !o_op_ready)
        else $error("command taken during a dump");

endmodule

@@ design/double_ended_queue.sv @@
// Top level of the double-ended queue: front-end command queue and back-end executor.
//
// A double-ended queue of signed words held in a ring store of DEPTH entries, driven by
// command beats (clear, push front, push back, dump, pop front, pop back) and answering
// with result beats of word, status and last. The front end takes a command beat in any
// cycle in which its two-beat command queue has room, so commands keep flowing while a
// result waits to be taken. The back end executes one command at a time: a clear or a
// successful push gives no result; a pop, an empty pop or a dropped push is taken and its
// result beat is marked pending, then written into the output buffer. A dump streams the
// stored entries front to back at one beat per cycle, set by the single read port of the
// ring store, while the buffer has room; the next command starts once the last
// entry has been read. Results pass through a two-beat output buffer. A stalled consumer
// holds back a pop, a dropped push or the next dump beat once the buffer, counting the
// result still being read from the store, has no free place left; clears and pushes that
// fit take no place in the buffer. The store needs no clearing after reset; only
// occupied entries are ever read. Command codes 6 and 7 are accepted and ignored.
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic signed [WORD_W-1:0] i_push_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [WORD_W-1:0] o_word,
    output logic [STATUS_W-1:0]      o_status,
    output logic                     o_last
);

    // Decoded commands waiting for the back end, with the push word already
    // brought to the storage width.
    t_op                   w_op;
    logic                  w_op_valid;
    logic                  w_op_ready;
    logic [DATA_WIDTH-1:0] w_op_value;

    deq_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_push_value (i_push_value),
        .o_op_valid   (w_op_valid),
        .i_op_ready   (w_op_ready),
        .o_op         (w_op),
        .o_op_value   (w_op_value)
    );

    // The back end owns the front index, the entry count and the ring store, and
    // sends every result beat through its own output buffer.
    deq_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (w_op_valid),
        .o_op_ready (w_op_ready),
        .i_op       (w_op),
        .i_op_value (w_op_value),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_word     (o_word),
        .o_status   (o_status),
        .o_last     (o_last)
    );

endmodule

@@ tb/sv/deq_checker.sv @@
// Result checker for the double-ended queue: command predictor and result comparison.
module deq_checker
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cmd_valid,
    input  logic                     i_cmd_ready,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic signed [WORD_W-1:0] i_push_value,
    input  logic                     i_res_valid,
    input  logic                     i_res_ready,
    input  logic signed [WORD_W-1:0] i_word,
    input  logic [STATUS_W-1:0]      i_status,
    input  logic                     i_last,
    output int                       o_mismatch_count,
    output int                       o_pending_count
);

    typedef struct packed {
        logic signed [WORD_W-1:0] word;
        logic [STATUS_W-1:0]      status;
        logic                     last;
    } t_result_beat;

    // Shadow copy of the queue contents.
    logic [DATA_WIDTH-1:0] shadow_ring [DEPTH];
    int unsigned           front_slot;
    int unsigned           occupancy;

    t_result_beat expected_beats [$];
    int           mismatch_total;

    function automatic logic signed [WORD_W-1:0] stored_to_word(
        input logic [DATA_WIDTH-1:0] stored
    );
        logic signed [DATA_WIDTH-1:0] narrow;
        logic signed [63:0]           wide;
        narrow = stored;
        wide   = narrow;
        return wide[WORD_W-1:0];
    endfunction

    task automatic expect_beat(input logic signed [WORD_W-1:0] word,
                               input logic [STATUS_W-1:0] status, input logic last);
        t_result_beat beat;
        beat.word   = word;
        beat.status = status;
        beat.last   = last;
        expected_beats.push_back(beat);
    endtask

    task automatic apply_command(input logic [CMD_W-1:0] cmd,
                                 input logic signed [WORD_W-1:0] value);
        int unsigned        slot;
        logic signed [63:0] wide;
        case (cmd)
            CMD_CLEAR: begin
                front_slot = 0;
                occupancy  = 0;
            end
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (occupancy >= DEPTH) begin
                    expect_beat('0, ST_FULL, 1'b1);
                end else begin
                    wide = value;
                    if (cmd == CMD_PUSH_FRONT) begin
                        front_slot = (front_slot + DEPTH - 1) % DEPTH;
                        slot       = front_slot;
                    end else begin
                        slot = (front_slot + occupancy) % DEPTH;
                    end
                    shadow_ring[slot] = wide[DATA_WIDTH-1:0];
                    occupancy++;
                end
            end
            CMD_DUMP: begin
                for (int unsigned k = 0; k < occupancy; k++) begin
                    expect_beat(stored_to_word(shadow_ring[(front_slot + k) % DEPTH]),
                                ST_DUMP, k + 1 == occupancy);
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (occupancy == 0) begin
                    expect_beat('0, ST_EMPTY, 1'b1);
                end else begin
                    if (cmd == CMD_POP_FRONT) begin
                        slot       = front_slot;
                        front_slot = (front_slot + 1) % DEPTH;
                    end else begin
                        slot = (front_slot + occupancy - 1) % DEPTH;
                    end
                    occupancy--;
                    expect_beat(stored_to_word(shadow_ring[slot]), ST_POP, 1'b1);
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_beat();
        t_result_beat want;
        if (expected_beats.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual word %h status %0d last %0b",
                     $time, i_word, i_status, i_last);
            mismatch_total++;
        end else begin
            want = expected_beats.pop_front();
            if (i_word !== want.word) begin
                $display("%0t: word mismatch, expected %h, actual %h", $time, want.word, i_word);
                mismatch_total++;
            end
            if (i_status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, i_status);
                mismatch_total++;
            end
            if (i_last !== want.last) begin
                $display("%0t: last mismatch, expected %0b, actual %0b", $time, want.last, i_last);
                mismatch_total++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_beats.delete();
            front_slot       = 0;
            occupancy        = 0;
            mismatch_total   = 0;
            o_mismatch_count <= 0;
            o_pending_count  <= 0;
        end else begin
            // Results always trail their command, so compare before predicting.
            if (i_res_valid && i_res_ready) begin
                check_beat();
            end
            if (i_cmd_valid && i_cmd_ready) begin
                apply_command(i_cmd, i_push_value);
            end
            o_mismatch_count <= mismatch_total;
            o_pending_count  <= expected_beats.size();
        end
    end

endmodule

@@ tb/sv/tb_double_ended_queue.sv @@
// Testbench top for the double-ended queue: clock, reset, stimulus, watchdog and verdict.
module tb_double_ended_queue;
    import deq_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int DATA_WIDTH  = DATA_WIDTH_DEF;
    // A full dump under heavy receiver stalls never goes this long without a beat.
    localparam int QUIET_LIMIT = 2000;
    // Cycles allowed after the last expected result for stray beats to show up.
    localparam int TAIL_CYCLES = 20;

    // The two command codes that the block takes and ignores.
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    logic                     i_clk;
    logic                     i_rst_n    = 1'b0;
    logic                     cmd_valid  = 1'b0;
    logic                     cmd_ready;
    logic [CMD_W-1:0]         cmd_code   = CMD_CLEAR;
    logic signed [WORD_W-1:0] push_value = '0;
    logic                     res_valid;
    logic                     res_ready  = 1'b0;
    logic signed [WORD_W-1:0] res_word;
    logic [STATUS_W-1:0]      res_status;
    logic                     res_last;

    int mismatch_count;
    int pending_count;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int quiet_cycles = 0;

    double_ended_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (cmd_valid),
        .o_ready      (cmd_ready),
        .i_cmd        (cmd_code),
        .i_push_value (push_value),
        .o_valid      (res_valid),
        .i_ready      (res_ready),
        .o_word       (res_word),
        .o_status     (res_status),
        .o_last       (res_last)
    );

    // The checker sees exactly the same beats as the block and keeps its own
    // copy of the queue, so the stimulus below never needs to know the contents.
    deq_checker #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (cmd_valid),
        .i_cmd_ready      (cmd_ready),
        .i_cmd            (cmd_code),
        .i_push_value     (push_value),
        .i_res_valid      (res_valid),
        .i_res_ready      (res_ready),
        .i_word           (res_word),
        .i_status         (res_status),
        .i_last           (res_last),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The receiver stalls on a fresh coin toss every cycle, so stalls land on
    // every position within a dump stream as well as on single pop results.
    always @(posedge i_clk) begin
        res_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Any cycle that moves a beat on either side counts as progress.
    always @(posedge i_clk) begin
        if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Uniform words half of the time, with the extremes, zero and minus one mixed in.
    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -1;
            default: return $urandom();
        endcase
    endfunction

    // Offers one command beat and holds it until accepted. Any idle cycles that
    // follow are decided here, so valid is only lowered when a real gap follows
    // and is never dropped and raised again within the same edge.
    task automatic send_command(input logic [CMD_W-1:0] code,
                                input logic signed [WORD_W-1:0] value);
        int gap;
        cmd_valid  <= 1'b1;
        cmd_code   <= code;
        push_value <= value;
        do @(posedge i_clk); while (cmd_ready !== 1'b1);
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Holds the sender back until the checker has nothing outstanding. The
    // first edge is always waited for, because the registered count lags the last beat.
    task automatic wait_for_drain();
        cmd_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    // Short hand-picked sequence: empty-queue cases, the word extremes, both
    // ends of the queue, the unused codes and the single-entry back pop.
    task automatic run_directed();
        send_command(CMD_POP_FRONT, '0);
        send_command(CMD_POP_BACK, '0);
        send_command(CMD_DUMP, '0);
        send_command(CMD_PUSH_FRONT, 32'sh7fff_ffff);
        send_command(CMD_PUSH_BACK, 32'sh8000_0000);
        send_command(CMD_PUSH_FRONT, -1);
        send_command(CMD_PUSH_BACK, '0);
        send_command(CMD_PUSH_BACK, 32'sh0000_0001);
        send_command(CMD_DUMP, 32'sh5a5a_5a5a);
        send_command(CMD_POP_BACK, '0);
        send_command(CMD_POP_FRONT, '0);
        send_command(CMD_SPARE_LO, 32'sh1234_5678);
        send_command(CMD_SPARE_HI, -1);
        send_command(CMD_DUMP, '0);
        send_command(CMD_CLEAR, 32'sh7fff_ffff);
        send_command(CMD_DUMP, '0);
        send_command(CMD_POP_BACK, '0);
        send_command(CMD_PUSH_BACK, 32'sh0000_0005);
        send_command(CMD_POP_BACK, '0);
        send_command(CMD_POP_FRONT, '0);
        send_command(CMD_PUSH_FRONT, 32'sh0000_0007);
        send_command(CMD_POP_FRONT, '0);
        send_command(CMD_DUMP, '0);
    endtask

    // One phase: fill the queue past full from both ends, dump it whole, take
    // from both ends, then a run of random commands biased towards pushes so
    // the queue keeps enough depth for long dumps and wrapping ring positions.
    task automatic run_phase(input int tx_pct, input int rx_pct, input int random_items);
        int               pick;
        logic [CMD_W-1:0] code;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        send_command(CMD_CLEAR, pick_word());
        repeat (DEPTH + 2) begin
            send_command($urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_word());
        end
        send_command(CMD_DUMP, pick_word());
        send_command(CMD_POP_FRONT, pick_word());
        send_command(CMD_POP_BACK, pick_word());
        repeat (random_items) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                code = CMD_PUSH_FRONT;
            end else if (pick < 50) begin
                code = CMD_PUSH_BACK;
            end else if (pick < 65) begin
                code = CMD_POP_FRONT;
            end else if (pick < 80) begin
                code = CMD_POP_BACK;
            end else if (pick < 90) begin
                code = CMD_DUMP;
            end else if (pick < 94) begin
                code = CMD_CLEAR;
            end else begin
                code = $urandom_range(1) ? CMD_SPARE_LO : CMD_SPARE_HI;
            end
            send_command(code, pick_word());
        end
        wait_for_drain();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 18;
        rx_idle_pct = 66;
        run_directed();
        wait_for_drain();

        // Sender mostly busy with a slow receiver, then the reverse, then flat out.
        run_phase(18, 66, 50);
        run_phase(66, 18, 50);
        run_phase(0, 0, 50);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
